### hw/rtl/rpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpe_pkg
// Widths and codes shared by the rumble pattern envelope core and its
// channel interfaces.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int STEP_W      = 12;
  localparam int DUR_W       = 16;
  localparam int SBYTES_W    = 3;
  localparam int INTENS_W    = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int INDEX_W     = 5;
  localparam int BYTE_W      = 8;
  localparam int ELAPSED_W   = 16;
  localparam int LEVEL_W     = 32;
  localparam int LEFTOVER_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LENGTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_DURATION = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_BYTES   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERPOLATE_ON = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTENSITY      = 3'd4;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  localparam logic [STEP_W-1:0]   STEP_RESET      = 12'd15;
  localparam logic [DUR_W-1:0]    DURATION_RESET  = 16'd30;
  localparam logic [SBYTES_W-1:0] SBYTES_RESET    = 3'd0;
  localparam logic [INTENS_W-1:0] INTENSITY_RESET = 8'd128;
  localparam logic [SBYTES_W-1:0] SBYTES_MAX      = 3'd4;

endpackage

`default_nettype wire

### hw/rtl/rpe_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpe_cmd_if
// Input channel: pattern byte writes and time ticks.
// ----------------------------------------------------------------------------
interface rpe_cmd_if;

  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [rpe_pkg::INDEX_W-1:0]   pattern_index;
  logic [rpe_pkg::BYTE_W-1:0]    pattern_byte;
  logic [rpe_pkg::ELAPSED_W-1:0] elapsed;

  modport source (output valid, action, pattern_index, pattern_byte, elapsed,
                  input ready);
  modport sink   (input valid, action, pattern_index, pattern_byte, elapsed,
                  output ready);

endinterface

`default_nettype wire

### hw/rtl/rpe_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpe_res_if
// Output channel: motor level, finished flag and leftover time.
// ----------------------------------------------------------------------------
interface rpe_res_if;

  logic                           valid;
  logic                           ready;
  logic [rpe_pkg::LEVEL_W-1:0]    level;
  logic                           finished;
  logic [rpe_pkg::LEFTOVER_W-1:0] leftover;

  modport source (output valid, level, finished, leftover, input ready);
  modport sink   (input valid, level, finished, leftover, output ready);

endinterface

`default_nettype wire

### hw/rtl/rumble_pattern_envelope_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rumble_pattern_envelope_core
// Vibration envelope generator with a pattern byte store, a shared restoring
// divider and a shared 32x32 multiplier under one sequencer.
// ----------------------------------------------------------------------------
// A write beat goes from acceptance straight to the result stage, which presents
// its result once the output is free. A tick divides the position by the step
// length, reads its samples from the store and, when blending, takes a reciprocal on
// the divider and blends on the multiplier. One beat is in work at a time.
// Synchronous reset restores the default registers, zeroes the position and
// marks every store entry as reading zero.
// ----------------------------------------------------------------------------
module rumble_pattern_envelope_core #(
  parameter int PATTERN_BYTES = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [rpe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [rpe_pkg::CFG_DATA_W-1:0]      cfg_data,
  rpe_cmd_if.sink                            cmd,
  rpe_res_if.source                          res
);

  localparam int ADDR_W = $clog2(PATTERN_BYTES);
  localparam int R8_W   = ADDR_W + 3;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV      = 4'd1;
  localparam logic [3:0] S_BASE     = 4'd2;
  localparam logic [3:0] S_RD_ISSUE = 4'd3;
  localparam logic [3:0] S_RD_CAP   = 4'd4;
  localparam logic [3:0] S_RECIP    = 4'd5;
  localparam logic [3:0] S_MUL_W    = 4'd6;
  localparam logic [3:0] S_MUL_A    = 4'd7;
  localparam logic [3:0] S_MUL_B    = 4'd8;
  localparam logic [3:0] S_SUM_V    = 4'd9;
  localparam logic [3:0] S_MUL_I    = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  function automatic logic [ADDR_W-1:0] wrap_index(input logic [rpe_pkg::INDEX_W-1:0] x);
    logic [13:0] r;
    r = 14'(x);
    for (int j = 5; j >= 0; j--) begin
      if (r >= (14'(PATTERN_BYTES) << j)) begin
        r = r - (14'(PATTERN_BYTES) << j);
      end
    end
    return r[ADDR_W-1:0];
  endfunction

  logic [rpe_pkg::STEP_W-1:0]   step_length;
  logic [rpe_pkg::DUR_W-1:0]    total_duration;
  logic [rpe_pkg::SBYTES_W-1:0] sample_bytes;
  logic                         interpolate_on;
  logic [rpe_pkg::INTENS_W-1:0] intensity;

  logic [3:0]                     state;
  logic [5:0]                     cnt;
  logic [rpe_pkg::STEP_W-1:0]     rem;
  logic [31:0]                    dvd;
  logic [31:0]                    quo;
  logic [ADDR_W-1:0]              r1;
  logic [R8_W-1:0]                r8;
  logic [ADDR_W-1:0]              rd_addr;
  logic [2:0]                     rd_cnt;
  logic [rpe_pkg::STEP_W-1:0]     frac;
  logic [31:0]                    cur;
  logic [31:0]                    nxt;
  logic [31:0]                    w;
  logic [31:0]                    acc;
  logic [63:0]                    prod;
  logic [rpe_pkg::ELAPSED_W-1:0]  elapsed_r;
  logic                           is_write;
  logic [rpe_pkg::DUR_W-1:0]      pos;
  logic                           out_valid;
  logic [rpe_pkg::LEVEL_W-1:0]    level_r;
  logic                           finished_r;
  logic [rpe_pkg::LEFTOVER_W-1:0] leftover_r;

  logic [rpe_pkg::BYTE_W-1:0] mem [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0]   mem_valid;
  logic [rpe_pkg::BYTE_W-1:0] rd_data;
  logic                       rd_valid;

  logic                          accept;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             mem_addr;
  logic                          bit_mode;
  logic [2:0]                    nbytes;
  logic [2:0]                    rd_last;
  logic [rpe_pkg::STEP_W-1:0]    dsr;
  logic [rpe_pkg::STEP_W:0]      div_t;
  logic                          div_bit;
  logic [rpe_pkg::STEP_W-1:0]    rem_next;
  logic [ADDR_W:0]               r1_t;
  logic [ADDR_W-1:0]             r1_next;
  logic [R8_W:0]                 r8_t;
  logic [R8_W-1:0]               r8_next;
  logic [R8_W-1:0]               r8_inc;
  logic [ADDR_W-1:0]             rd_addr_inc;
  logic [ADDR_W:0]               base_sum;
  logic [ADDR_W-1:0]             base_next;
  logic [rpe_pkg::BYTE_W-1:0]    rd_byte;
  logic                          rd_bit;
  logic [2:0]                    slot_wide;
  logic [4:0]                    slot_shift;
  logic [31:0]                   placed;
  logic [31:0]                   mul_x;
  logic [31:0]                   mul_y;
  logic                          out_free;
  logic [rpe_pkg::DUR_W:0]       pos_sum;
  logic [rpe_pkg::DUR_W:0]       left_wide;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign wr_en     = accept && (cmd.action == rpe_pkg::ACTION_WRITE);
  assign wr_addr   = wrap_index(cmd.pattern_index);

  assign bit_mode = (sample_bytes == '0);
  assign nbytes   = (sample_bytes > rpe_pkg::SBYTES_MAX) ? rpe_pkg::SBYTES_MAX : sample_bytes;
  assign rd_last  = bit_mode ? 3'd1 : 3'((4'(nbytes) << 1) - 4'd1);
  assign mem_addr = bit_mode ? r8[R8_W-1:3] : rd_addr;

  assign dsr      = (step_length == '0) ? rpe_pkg::STEP_W'(1) : step_length;
  assign div_t    = {rem, dvd[31]};
  assign div_bit  = (div_t >= {1'b0, dsr});
  assign rem_next = div_bit ? rpe_pkg::STEP_W'(div_t - {1'b0, dsr})
                            : div_t[rpe_pkg::STEP_W-1:0];

  assign r1_t    = {r1, div_bit};
  assign r1_next = (r1_t >= (ADDR_W+1)'(PATTERN_BYTES))
                   ? ADDR_W'(r1_t - (ADDR_W+1)'(PATTERN_BYTES)) : r1_t[ADDR_W-1:0];
  assign r8_t    = {r8, div_bit};
  assign r8_next = (r8_t >= (R8_W+1)'(8 * PATTERN_BYTES))
                   ? R8_W'(r8_t - (R8_W+1)'(8 * PATTERN_BYTES)) : r8_t[R8_W-1:0];

  assign r8_inc      = (r8 == R8_W'(8 * PATTERN_BYTES - 1)) ? '0 : r8 + R8_W'(1);
  assign rd_addr_inc = (rd_addr == ADDR_W'(PATTERN_BYTES - 1)) ? '0 : rd_addr + ADDR_W'(1);
  assign base_sum    = {1'b0, rd_addr} + {1'b0, r1};
  assign base_next   = (base_sum >= (ADDR_W+1)'(PATTERN_BYTES))
                       ? ADDR_W'(base_sum - (ADDR_W+1)'(PATTERN_BYTES)) : base_sum[ADDR_W-1:0];

  assign rd_byte    = rd_valid ? rd_data : '0;
  assign rd_bit     = rd_byte[r8[2:0]];
  assign slot_wide  = (rd_cnt < nbytes) ? rd_cnt : rd_cnt - nbytes;
  assign slot_shift = {slot_wide[1:0], 3'b000};
  assign placed     = {rd_byte, 24'd0} >> slot_shift;

  assign out_free  = !out_valid || res.ready;
  assign pos_sum   = {1'b0, pos} + {1'b0, elapsed_r};
  assign left_wide = pos_sum - {1'b0, total_duration};

  always_comb begin
    case (state)
      S_MUL_W: begin
        mul_x = quo + 32'd1;
        mul_y = 32'(frac);
      end
      S_MUL_A: begin
        mul_x = cur;
        mul_y = 32'd0 - prod[31:0];
      end
      S_MUL_B: begin
        mul_x = nxt;
        mul_y = w;
      end
      S_MUL_I: begin
        mul_x = acc;
        mul_y = 32'(intensity);
      end
      default: begin
        mul_x = cur;
        mul_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.pattern_byte;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        mem_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= mem_valid[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length    <= rpe_pkg::STEP_RESET;
      total_duration <= rpe_pkg::DURATION_RESET;
      sample_bytes   <= rpe_pkg::SBYTES_RESET;
      interpolate_on <= 1'b0;
      intensity      <= rpe_pkg::INTENSITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rpe_pkg::CFG_STEP_LENGTH:    step_length    <= cfg_data[rpe_pkg::STEP_W-1:0];
        rpe_pkg::CFG_TOTAL_DURATION: total_duration <= cfg_data[rpe_pkg::DUR_W-1:0];
        rpe_pkg::CFG_SAMPLE_BYTES:   sample_bytes   <= cfg_data[rpe_pkg::SBYTES_W-1:0];
        rpe_pkg::CFG_INTERPOLATE_ON: interpolate_on <= cfg_data[0];
        rpe_pkg::CFG_INTENSITY:      intensity      <= cfg_data[rpe_pkg::INTENS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_write  <= (cmd.action == rpe_pkg::ACTION_WRITE);
            elapsed_r <= cmd.elapsed;
            rem       <= '0;
            dvd       <= {pos, 16'd0};
            cnt       <= 6'd16;
            r1        <= '0;
            r8        <= '0;
            rd_cnt    <= '0;
            cur       <= '0;
            nxt       <= '0;
            state     <= (cmd.action == rpe_pkg::ACTION_WRITE) ? S_FIN : S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          dvd <= {dvd[30:0], 1'b0};
          quo <= {quo[30:0], div_bit};
          r1  <= r1_next;
          r8  <= r8_next;
          if (cnt == 6'd1) begin
            frac    <= interpolate_on ? rem_next : '0;
            rd_addr <= '0;
            cnt     <= 6'(nbytes);
            state   <= bit_mode ? S_RD_ISSUE : S_BASE;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_BASE: begin
          rd_addr <= base_next;
          cnt     <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_RD_ISSUE;
          end
        end
        S_RD_ISSUE: begin
          state <= S_RD_CAP;
        end
        S_RD_CAP: begin
          if (bit_mode) begin
            if (rd_cnt == '0) begin
              cur <= {32{rd_bit}};
            end else begin
              nxt <= {32{rd_bit}};
            end
            r8 <= r8_inc;
          end else begin
            if (rd_cnt < nbytes) begin
              cur <= cur | placed;
            end else begin
              nxt <= nxt | placed;
            end
            rd_addr <= rd_addr_inc;
          end
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt == rd_last) begin
            acc <= cur;
            if (frac != '0) begin
              rem   <= '0;
              dvd   <= '1;
              quo   <= '0;
              cnt   <= 6'd32;
              state <= S_RECIP;
            end else begin
              state <= S_MUL_I;
            end
          end else begin
            state <= S_RD_ISSUE;
          end
        end
        S_RECIP: begin
          rem <= rem_next;
          dvd <= {dvd[30:0], 1'b0};
          quo <= {quo[30:0], div_bit};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_MUL_W;
          end
        end
        S_MUL_W: begin
          prod  <= mul_x * mul_y;
          state <= S_MUL_A;
        end
        S_MUL_A: begin
          w     <= prod[31:0];
          prod  <= mul_x * mul_y;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          acc   <= prod[63:32];
          prod  <= mul_x * mul_y;
          state <= S_SUM_V;
        end
        S_SUM_V: begin
          acc   <= acc + prod[63:32];
          state <= S_MUL_I;
        end
        S_MUL_I: begin
          prod  <= mul_x * mul_y;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            if (is_write) begin
              level_r    <= '0;
              finished_r <= 1'b0;
              leftover_r <= '0;
            end else begin
              level_r <= (prod[63:39] != '0) ? '1 : prod[38:7];
              if (pos_sum >= {1'b0, total_duration}) begin
                finished_r <= 1'b1;
                leftover_r <= left_wide[rpe_pkg::DUR_W] ? '1
                                                         : left_wide[rpe_pkg::DUR_W-1:0];
                pos        <= '0;
              end else begin
                finished_r <= 1'b0;
                leftover_r <= '0;
                pos        <= pos_sum[rpe_pkg::DUR_W-1:0];
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid    = out_valid;
  assign res.level    = level_r;
  assign res.finished = finished_r;
  assign res.leftover = leftover_r;

  a_write_to_fin: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.action == rpe_pkg::ACTION_WRITE) |=> (state == S_FIN))
    else $error("write beat did not go straight to the result stage");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> ($past(state) == S_FIN))
    else $error("result appeared outside the result stage");

  a_fin_release: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (state == S_IDLE && res.valid))
    else $error("result stage did not hand over its beat");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_CAP) |-> ($past(state) == S_RD_ISSUE))
    else $error("store data captured without a read issued");

endmodule

`default_nettype wire
